// ----- src/twus_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twus_pkg
// Shared types and constants for the task window usage statistics block.
// ----------------------------------------------------------------------------
package twus_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int TASK_W          = 32;
   localparam int MEM_W           = 48;
   localparam int TIME_W          = 48;
   localparam int CPU_W           = 49;
   localparam int CPU_MS_W        = 39;
   localparam int SUM_W           = 64;
   localparam int SAMPLE_COUNT_W  = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // restoring divider: one quotient bit per step over the full sum width
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int USEC_PER_MS = 1000;
   localparam int CPU_ROUND   = USEC_PER_MS - 1;

   // usec / 1000 = (usec >> 3) / 125, done as a multiply by ceil(2^53 / 125);
   // exact for every 46-bit operand
   localparam int CPU_PRE_SHIFT = 3;
   localparam int CPU_M_W       = CPU_W - CPU_PRE_SHIFT;
   localparam int CPU_M_PART_W  = CPU_M_W / 2;
   localparam int RECIP_W       = 47;
   localparam int RECIP_LO_W    = 24;
   localparam int RECIP_SHIFT   = 53;
   localparam int CPU_PP_W      = CPU_M_PART_W + RECIP_LO_W;
   localparam int CPU_PROD_W    = CPU_M_W + RECIP_W;
   localparam int CPU_MUL_STEPS = 4;
   localparam logic [RECIP_W-1:0] CPU_RECIP = 47'd72057594037928;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic STATUS_RECORDED  = 1'b0;
   localparam logic STATUS_DISCARDED = 1'b1;

   typedef enum logic [1:0] {
      CMD_BEGIN  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_END    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

   // one finished window handed from the front to the back
   typedef struct packed {
      logic [TASK_W-1:0]      task_id;
      logic                   status;
      logic [TIME_W-1:0]      start_ms;
      logic [TIME_W-1:0]      end_ms;
      logic [CPU_W-1:0]       cpu_num;   // rounded-up numerator, zero if invalid
      logic [MEM_W-1:0]       baseline;
      logic [SUM_W-1:0]       sum;
      logic [COUNT_WIDTH-1:0] count;
      logic [MEM_W-1:0]       peak;
   } job_type;

endpackage

// ----- src/twus_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twus_front
// Accepts command words, keeps the open window and emits one job per end.
// ----------------------------------------------------------------------------
module twus_front
   import twus_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [TASK_W-1:0]        req_task_id,
   input  logic [MEM_W-1:0]         req_rss_bytes,
   input  logic [TIME_W-1:0]        req_time_ms,
   input  logic signed [CPU_W-1:0]  req_cpu_usec,
   output logic                     job_valid,
   input  logic                     job_ready,
   output job_type                  job
);

   logic [TASK_W-1:0]        open_task_ff, open_task_in;
   logic [TIME_W-1:0]        start_ff, start_in;
   logic signed [CPU_W-1:0]  begin_cpu_ff, begin_cpu_in;
   logic [MEM_W-1:0]         base_ff, base_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [MEM_W-1:0]         peak_ff, peak_in;

   logic                     accept;
   logic                     sample_ok;
   logic [SUM_W-1:0]         smp_sum;
   logic [COUNT_WIDTH-1:0]   smp_cnt;
   logic [MEM_W-1:0]         smp_peak;
   logic                     cpu_ok;
   logic signed [CPU_W-1:0]  cpu_diff;
   logic                     matched;

   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;

   // window with a sample folded in
   always_comb begin
      sample_ok = (open_task_ff != '0) && (req_rss_bytes != '0);
      smp_sum   = sum_ff;
      smp_cnt   = cnt_ff;
      smp_peak  = peak_ff;
      if (sample_ok) begin
         if (cnt_ff != COUNT_MAX) begin
            smp_sum = sum_ff + SUM_W'(req_rss_bytes);
            smp_cnt = cnt_ff + COUNT_WIDTH'(1);
         end
         if (req_rss_bytes > peak_ff) begin
            smp_peak = req_rss_bytes;
         end
      end
   end

   assign cpu_ok   = (req_cpu_usec > 0) && (begin_cpu_ff > 0) &&
                     (req_cpu_usec >= begin_cpu_ff);
   assign cpu_diff = req_cpu_usec - begin_cpu_ff;
   assign matched  = (open_task_ff == req_task_id) && (open_task_ff != '0);

   always_comb begin
      open_task_in = open_task_ff;
      start_in     = start_ff;
      begin_cpu_in = begin_cpu_ff;
      base_in      = base_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      peak_in      = peak_ff;
      job_valid    = 1'b0;
      job          = '0;
      job.task_id  = req_task_id;
      job.status   = STATUS_DISCARDED;
      case (cmd_type'(req_command))
         CMD_BEGIN: begin
            if (accept) begin
               open_task_in = req_task_id;
               start_in     = req_time_ms;
               begin_cpu_in = req_cpu_usec;
               base_in      = req_rss_bytes;
               sum_in       = SUM_W'(req_rss_bytes);
               cnt_in       = COUNT_WIDTH'(1);
               peak_in      = req_rss_bytes;
            end
         end
         CMD_SAMPLE: begin
            if (accept) begin
               sum_in  = smp_sum;
               cnt_in  = smp_cnt;
               peak_in = smp_peak;
            end
         end
         CMD_END: begin
            job_valid = req_valid;
            if (matched) begin
               job.status   = STATUS_RECORDED;
               job.start_ms = start_ff;
               job.end_ms   = req_time_ms;
               job.cpu_num  = cpu_ok ? (CPU_W'(unsigned'(cpu_diff)) + CPU_W'(CPU_ROUND))
                                     : '0;
               job.baseline = base_ff;
               job.sum      = smp_sum;
               job.count    = smp_cnt;
               job.peak     = smp_peak;
            end
            if (accept) begin
               open_task_in = '0;
               start_in     = '0;
               begin_cpu_in = '0;
               base_in      = '0;
               sum_in       = '0;
               cnt_in       = '0;
               peak_in      = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_task_ff <= '0;
         start_ff     <= '0;
         begin_cpu_ff <= '0;
         base_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         peak_ff      <= '0;
      end else begin
         open_task_ff <= open_task_in;
         start_ff     <= start_in;
         begin_cpu_ff <= begin_cpu_in;
         base_ff      <= base_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         peak_ff      <= peak_in;
      end
   end

endmodule

// ----- src/twus_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twus_queue
// Short job queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module twus_queue
   import twus_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]     level_ff, level_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (level_ff != QLVL_W'(QUEUE_DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + QLVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - QLVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- src/twus_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twus_back
// Runs the average division and CPU millisecond scaling, holds the result word.
// ----------------------------------------------------------------------------
module twus_back
   import twus_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_ready,
   input  job_type                     job,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [TASK_W-1:0]           rsp_task_id_res,
   output logic                        rsp_status,
   output logic [TIME_W-1:0]           rsp_start_ms,
   output logic [TIME_W-1:0]           rsp_end_ms,
   output logic [CPU_MS_W-1:0]         rsp_cpu_ms,
   output logic [MEM_W-1:0]            rsp_mem_baseline,
   output logic [MEM_W-1:0]            rsp_mem_average,
   output logic [MEM_W-1:0]            rsp_mem_peak,
   output logic [SAMPLE_COUNT_W-1:0]   rsp_sample_count
);

   back_state_type           state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   job_type                  hold_ff;

   // quotient bits shift in at the bottom as numerator bits leave the top
   logic [SUM_W-1:0]         sum_q_ff, sum_q_in;
   logic [COUNT_WIDTH-1:0]   sum_rem_ff, sum_rem_in;

   logic [COUNT_WIDTH:0]     sum_trial;

   // reciprocal multiply, one partial product per cycle
   logic [CPU_M_W-1:0]       cpu_m;
   logic                     mul_en;
   logic                     cpu_m_hi;
   logic                     cpu_r_hi;
   logic [CPU_M_PART_W-1:0]  cpu_m_part;
   logic [RECIP_LO_W-1:0]    cpu_r_part;
   logic [CPU_PP_W-1:0]      cpu_pp;
   logic [CPU_PROD_W-1:0]    cpu_term;
   logic [CPU_PROD_W-1:0]    cpu_acc_ff, cpu_acc_in;

   logic                     out_free;
   logic                     load_job;
   logic                     div_en;
   logic                     load_out;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TASK_W-1:0]        task_ff;
   logic                     status_ff;
   logic [TIME_W-1:0]        start_ff;
   logic [TIME_W-1:0]        end_ff;
   logic [CPU_MS_W-1:0]      cpu_ms_ff;
   logic [MEM_W-1:0]         base_ff;
   logic [MEM_W-1:0]         avg_ff;
   logic [MEM_W-1:0]         peak_ff;
   logic [SAMPLE_COUNT_W-1:0] count_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (step_ff == '0) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      job_ready = 1'b0;
      div_en    = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         BK_IDLE: job_ready = 1'b1;
         BK_DIV:  div_en    = 1'b1;
         BK_DONE: load_out  = out_free;
         default: begin
         end
      endcase
   end

   assign load_job  = job_valid && job_ready;
   assign sum_trial = {sum_rem_ff, sum_q_ff[SUM_W-1]};

   // first four divider steps: low x low, low x high, high x low, high x high
   assign cpu_m      = hold_ff.cpu_num[CPU_W-1:CPU_PRE_SHIFT];
   assign mul_en     = div_en && (step_ff >= STEP_W'(DIV_STEPS - CPU_MUL_STEPS));
   assign cpu_m_hi   = !step_ff[1];
   assign cpu_r_hi   = !step_ff[0];
   assign cpu_m_part = cpu_m_hi ? cpu_m[CPU_M_W-1:CPU_M_PART_W] : cpu_m[CPU_M_PART_W-1:0];
   assign cpu_r_part = cpu_r_hi ? RECIP_LO_W'(CPU_RECIP[RECIP_W-1:RECIP_LO_W])
                                : CPU_RECIP[RECIP_LO_W-1:0];
   assign cpu_pp     = CPU_PP_W'(cpu_m_part) * CPU_PP_W'(cpu_r_part);

   always_comb begin
      cpu_term = CPU_PROD_W'(cpu_pp);
      if (cpu_m_hi) begin
         cpu_term = cpu_term << CPU_M_PART_W;
      end
      if (cpu_r_hi) begin
         cpu_term = cpu_term << RECIP_LO_W;
      end
   end

   always_comb begin
      step_in    = step_ff;
      sum_q_in   = sum_q_ff;
      sum_rem_in = sum_rem_ff;
      cpu_acc_in = cpu_acc_ff;
      if (load_job) begin
         step_in    = STEP_W'(DIV_STEPS - 1);
         sum_q_in   = job.sum;
         sum_rem_in = '0;
         cpu_acc_in = '0;
      end else if (div_en) begin
         step_in = step_ff - STEP_W'(1);
         if (sum_trial >= {1'b0, hold_ff.count}) begin
            sum_rem_in = COUNT_WIDTH'(sum_trial - {1'b0, hold_ff.count});
            sum_q_in   = {sum_q_ff[SUM_W-2:0], 1'b1};
         end else begin
            sum_rem_in = COUNT_WIDTH'(sum_trial);
            sum_q_in   = {sum_q_ff[SUM_W-2:0], 1'b0};
         end
         if (mul_en) begin
            cpu_acc_in = cpu_acc_ff + cpu_term;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      sum_q_ff   <= sum_q_in;
      sum_rem_ff <= sum_rem_in;
      cpu_acc_ff <= cpu_acc_in;
      if (load_job) begin
         hold_ff <= job;
      end
      if (load_out) begin
         task_ff   <= hold_ff.task_id;
         status_ff <= hold_ff.status;
         start_ff  <= hold_ff.start_ms;
         end_ff    <= hold_ff.end_ms;
         cpu_ms_ff <= cpu_acc_ff[RECIP_SHIFT+CPU_MS_W-1:RECIP_SHIFT];
         base_ff   <= hold_ff.baseline;
         // zero count only on a discarded word
         avg_ff    <= (hold_ff.count == '0) ? '0 : sum_q_ff[MEM_W-1:0];
         peak_ff   <= hold_ff.peak;
         count_ff  <= SAMPLE_COUNT_W'(hold_ff.count);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_task_id_res  = task_ff;
   assign rsp_status       = status_ff;
   assign rsp_start_ms     = start_ff;
   assign rsp_end_ms       = end_ff;
   assign rsp_cpu_ms       = cpu_ms_ff;
   assign rsp_mem_baseline = base_ff;
   assign rsp_mem_average  = avg_ff;
   assign rsp_mem_peak     = peak_ff;
   assign rsp_sample_count = count_ff;

endmodule

// ----- src/task_window_usage_stats_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_window_usage_stats_top
// Memory usage statistics over one task window, reported at window end.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries command words (begin, sample, end). Begin and sample words
//   only update the open window and give no result; each end word gives one
//   rsp_* word: the window statistics, or a discard status on a mismatch.
//   Begin and sample words are taken one per cycle while the job queue has
//   room. An end word is pushed into a two-entry queue; the back end then
//   runs a restoring divider for sum / count, one bit per cycle over 64
//   steps, and during its first four steps forms CPU usec / 1000 by a
//   reciprocal multiply. The back end takes the next end word from the
//   queue only once the current result is in the output register.
//   req_ready drops only while the job queue is full.
//   A finished word waits in the output register while rsp_ready is low;
//   the divider holds its result meanwhile and the queue keeps filling.
//   Synchronous active-high reset closes the window, empties the queue and
//   drops rsp_valid.
// ----------------------------------------------------------------------------
module task_window_usage_stats_top
   import twus_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_command,
   input  logic [TASK_W-1:0]           req_task_id,
   input  logic [MEM_W-1:0]            req_rss_bytes,
   input  logic [TIME_W-1:0]           req_time_ms,
   input  logic signed [CPU_W-1:0]     req_cpu_usec,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [TASK_W-1:0]           rsp_task_id_res,
   output logic                        rsp_status,
   output logic [TIME_W-1:0]           rsp_start_ms,
   output logic [TIME_W-1:0]           rsp_end_ms,
   output logic [CPU_MS_W-1:0]         rsp_cpu_ms,
   output logic [MEM_W-1:0]            rsp_mem_baseline,
   output logic [MEM_W-1:0]            rsp_mem_average,
   output logic [MEM_W-1:0]            rsp_mem_peak,
   output logic [SAMPLE_COUNT_W-1:0]   rsp_sample_count
);

   logic    fj_valid;
   logic    fj_ready;
   job_type fj_job;
   logic    bj_valid;
   logic    bj_ready;
   job_type bj_job;

   twus_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_task_id   (req_task_id),
      .req_rss_bytes (req_rss_bytes),
      .req_time_ms   (req_time_ms),
      .req_cpu_usec  (req_cpu_usec),
      .job_valid     (fj_valid),
      .job_ready     (fj_ready),
      .job           (fj_job)
   );

   twus_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_ready (fj_ready),
      .push_job   (fj_job),
      .pop_valid  (bj_valid),
      .pop_ready  (bj_ready),
      .pop_job    (bj_job)
   );

   twus_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (bj_valid),
      .job_ready        (bj_ready),
      .job              (bj_job),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_task_id_res  (rsp_task_id_res),
      .rsp_status       (rsp_status),
      .rsp_start_ms     (rsp_start_ms),
      .rsp_end_ms       (rsp_end_ms),
      .rsp_cpu_ms       (rsp_cpu_ms),
      .rsp_mem_baseline (rsp_mem_baseline),
      .rsp_mem_average  (rsp_mem_average),
      .rsp_mem_peak     (rsp_mem_peak),
      .rsp_sample_count (rsp_sample_count)
   );

   // a discarded word carries no statistics
   a_discard_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DISCARDED) |->
         (rsp_sample_count == '0 && rsp_mem_peak == '0 && rsp_cpu_ms == '0))
      else $error("discarded word has nonzero statistics");

   // a recorded window always holds at least the baseline sample
   a_recorded_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_RECORDED) |-> (rsp_sample_count != '0))
      else $error("recorded window with zero samples");

   // the divider result can never exceed the largest sample
   a_avg_le_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_RECORDED) |-> (rsp_mem_average <= rsp_mem_peak))
      else $error("average above peak");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for task_window_usage_stats_top. A directed part covers
// field extremes, every command and the corner cases (task 0 windows,
// mismatched ends, invalid CPU readings). A random part follows: mostly
// well-formed begin/sample/end windows with random content, mixed with noise
// words. It runs under several sender and receiver idle patterns and one
// long receiver hold-off that backs up the input.
// A predictor in a scoreboard class builds each expected result word, and
// every accepted result word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module testbench;
   import twus_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 2000;

   typedef struct packed {
      logic [TASK_W-1:0]         task_id;
      logic                      status;
      logic [TIME_W-1:0]         start_ms;
      logic [TIME_W-1:0]         end_ms;
      logic [CPU_MS_W-1:0]       cpu_ms;
      logic [MEM_W-1:0]          baseline;
      logic [MEM_W-1:0]          average;
      logic [MEM_W-1:0]          peak;
      logic [SAMPLE_COUNT_W-1:0] count;
   } window_report;

   class window_stats_board;
      logic [TASK_W-1:0]      open_tid;
      logic [TIME_W-1:0]      start_at;
      longint                 cpu_at_begin;
      logic [MEM_W-1:0]       base_mem;
      logic [SUM_W-1:0]       mem_sum;
      logic [COUNT_WIDTH-1:0] mem_count;
      logic [MEM_W-1:0]       mem_peak;
      window_report           pending_reports[$];
      int                     errors;
      int                     words_seen;
      int                     recorded_seen;
      int                     discarded_seen;

      function new();
         close_window();
         errors = 0;
         words_seen = 0;
         recorded_seen = 0;
         discarded_seen = 0;
      endfunction

      function void close_window();
         open_tid = '0;
         start_at = '0;
         cpu_at_begin = 0;
         base_mem = '0;
         mem_sum = '0;
         mem_count = '0;
         mem_peak = '0;
      endfunction

      function void fold_reading(logic [MEM_W-1:0] rss);
         if (open_tid == '0 || rss == '0) return;
         // saturated count: only the peak keeps moving
         if (mem_count < COUNT_MAX) begin
            mem_sum = mem_sum + rss;
            mem_count = mem_count + 1'b1;
         end
         if (rss > mem_peak) mem_peak = rss;
      endfunction

      function void note_word(logic [1:0] cmd, logic [TASK_W-1:0] tid,
                              logic [MEM_W-1:0] rss, logic [TIME_W-1:0] now,
                              logic signed [CPU_W-1:0] cpu);
         window_report r;
         longint cpu_now;
         logic [SUM_W-1:0] avg;
         r = '0;
         cpu_now = cpu;
         words_seen++;
         case (cmd)
            CMD_BEGIN: begin
               open_tid = tid;
               start_at = now;
               cpu_at_begin = cpu_now;
               base_mem = rss;
               mem_sum = {{(SUM_W-MEM_W){1'b0}}, rss};
               mem_count = 1;
               mem_peak = rss;
            end
            CMD_SAMPLE: fold_reading(rss);
            CMD_END: begin
               r.task_id = tid;
               if (open_tid == '0 || open_tid != tid) begin
                  r.status = STATUS_DISCARDED;
               end else begin
                  fold_reading(rss);
                  r.status = STATUS_RECORDED;
                  r.start_ms = start_at;
                  r.end_ms = now;
                  if (cpu_now > 0 && cpu_at_begin > 0 && cpu_now >= cpu_at_begin)
                     r.cpu_ms = CPU_MS_W'((cpu_now - cpu_at_begin + CPU_ROUND) /
                                          USEC_PER_MS);
                  r.baseline = base_mem;
                  avg = (mem_count != '0) ? mem_sum / mem_count : '0;
                  r.average = avg[MEM_W-1:0];
                  r.peak = mem_peak;
                  r.count = mem_count;
               end
               close_window();
               pending_reports.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_report(window_report got);
         window_report want;
         if (pending_reports.size() == 0) begin
            $error("result word for task %0h with nothing pending", got.task_id);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         if (want.status == STATUS_RECORDED) recorded_seen++;
         else discarded_seen++;
         check_field("task_id_res", want.task_id, got.task_id);
         check_field("status", want.status, got.status);
         check_field("start_ms", want.start_ms, got.start_ms);
         check_field("end_ms", want.end_ms, got.end_ms);
         check_field("cpu_ms", want.cpu_ms, got.cpu_ms);
         check_field("mem_baseline", want.baseline, got.baseline);
         check_field("mem_average", want.average, got.average);
         check_field("mem_peak", want.peak, got.peak);
         check_field("sample_count", want.count, got.count);
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_command = CMD_BEGIN;
   logic [TASK_W-1:0]           req_task_id = '0;
   logic [MEM_W-1:0]            req_rss_bytes = '0;
   logic [TIME_W-1:0]           req_time_ms = '0;
   logic signed [CPU_W-1:0]     req_cpu_usec = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [TASK_W-1:0]           rsp_task_id_res;
   logic                        rsp_status;
   logic [TIME_W-1:0]           rsp_start_ms;
   logic [TIME_W-1:0]           rsp_end_ms;
   logic [CPU_MS_W-1:0]         rsp_cpu_ms;
   logic [MEM_W-1:0]            rsp_mem_baseline;
   logic [MEM_W-1:0]            rsp_mem_average;
   logic [MEM_W-1:0]            rsp_mem_peak;
   logic [SAMPLE_COUNT_W-1:0]   rsp_sample_count;

   window_stats_board board = new();

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_on = 1'b0;
   int hold_left = 0;
   int words_left;
   logic [TASK_W-1:0] last_tid = 32'd1;

   task_window_usage_stats_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_task_id      (req_task_id),
      .req_rss_bytes    (req_rss_bytes),
      .req_time_ms      (req_time_ms),
      .req_cpu_usec     (req_cpu_usec),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_task_id_res  (rsp_task_id_res),
      .rsp_status       (rsp_status),
      .rsp_start_ms     (rsp_start_ms),
      .rsp_end_ms       (rsp_end_ms),
      .rsp_cpu_ms       (rsp_cpu_ms),
      .rsp_mem_baseline (rsp_mem_baseline),
      .rsp_mem_average  (rsp_mem_average),
      .rsp_mem_peak     (rsp_mem_peak),
      .rsp_sample_count (rsp_sample_count)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, or a counted hold-off once it is switched on
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else if (hold_on && hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // handshake monitor
   always @(posedge clock) begin
      window_report got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.task_id = rsp_task_id_res;
            got.status = rsp_status;
            got.start_ms = rsp_start_ms;
            got.end_ms = rsp_end_ms;
            got.cpu_ms = rsp_cpu_ms;
            got.baseline = rsp_mem_baseline;
            got.average = rsp_mem_average;
            got.peak = rsp_mem_peak;
            got.count = rsp_sample_count;
            board.check_report(got);
         end
         if (req_valid && req_ready)
            board.note_word(req_command, req_task_id, req_rss_bytes, req_time_ms,
                            req_cpu_usec);
      end
   end

   task automatic send_word(input logic [1:0] cmd, input logic [TASK_W-1:0] tid,
                            input logic [MEM_W-1:0] rss, input logic [TIME_W-1:0] now,
                            input logic signed [CPU_W-1:0] cpu);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_task_id <= tid;
      req_rss_bytes <= rss;
      req_time_ms <= now;
      req_cpu_usec <= cpu;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [MEM_W-1:0] rand_mem();
      case ($urandom_range(7))
         0: return '0;
         1: return {MEM_W{1'b1}};
         2, 3: return MEM_W'({$urandom, $urandom});
         default: return MEM_W'($urandom_range(1, 32'h4000_0000));
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      return TIME_W'({$urandom, $urandom});
   endfunction

   function automatic logic signed [CPU_W-1:0] rand_cpu();
      case ($urandom_range(7))
         0: return -1;
         1: return '0;
         2, 3: return CPU_W'({$urandom, $urandom});
         4: return {1'b0, {(CPU_W-1){1'b1}}};
         default: return CPU_W'($urandom_range(1, 32'h7FFF_FFFF));
      endcase
   endfunction

   // begin, a few samples, end with the same task
   task automatic send_window();
      logic [TASK_W-1:0] tid;
      logic [TIME_W-1:0] t0;
      logic signed [CPU_W-1:0] c0;
      logic signed [CPU_W-1:0] c1;
      int k;
      tid = $urandom;
      if (tid == '0) tid = 32'd1;
      last_tid = tid;
      t0 = rand_time();
      c0 = rand_cpu();
      send_word(CMD_BEGIN, tid, rand_mem(), t0, c0);
      k = $urandom_range(0, 6);
      repeat (k) send_word(CMD_SAMPLE, $urandom, rand_mem(), rand_time(), rand_cpu());
      if ($urandom_range(9) < 7) c1 = c0 + CPU_W'($urandom_range(0, 4_000_000));
      else c1 = rand_cpu();
      send_word(CMD_END, tid, rand_mem(), t0 + TIME_W'($urandom_range(0, 100_000)), c1);
      words_left -= k + 2;
   endtask

   task automatic send_noise();
      logic [TASK_W-1:0] tid;
      case ($urandom_range(2))
         0: tid = '0;
         1: tid = last_tid;
         default: tid = $urandom;
      endcase
      send_word(2'($urandom_range(3)), tid, rand_mem(), rand_time(), rand_cpu());
      words_left--;
   endtask

   task automatic run_random(input int n);
      words_left = n;
      while (words_left > 0) begin
         if ($urandom_range(99) < 75) send_window();
         else send_noise();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end with nothing open, and a sample with no window
      send_word(CMD_END, '0, rand_mem(), rand_time(), rand_cpu());
      send_word(CMD_SAMPLE, 32'd9, 48'd100, '0, '0);
      // a task 0 window never opens
      send_word(CMD_BEGIN, '0, 48'd500, 48'd10, 49'sd100);
      send_word(CMD_SAMPLE, '0, 48'd900, '0, '0);
      send_word(CMD_END, '0, 48'd700, 48'd20, 49'sd5000);
      // zero baseline, ignored zero sample, max reading, unused command
      send_word(CMD_BEGIN, 32'd1, '0, '0, 49'sd1);
      send_word(CMD_SAMPLE, 32'd1, '0, '0, '0);
      send_word(CMD_SAMPLE, 32'd1, {MEM_W{1'b1}}, '0, '0);
      send_word(CMD_UNUSED, 32'd1, 48'd77, 48'd77, 49'sd77);
      send_word(CMD_END, 32'd1, 48'd1, {TIME_W{1'b1}}, {1'b0, {(CPU_W-1){1'b1}}});
      // begin while open drops the old window; end for the old task is a mismatch
      send_word(CMD_BEGIN, 32'hFFFF_FFFF, 48'd4, 48'd4, 49'sd4);
      send_word(CMD_BEGIN, 32'd5, 48'd6, 48'd6, 49'sd6);
      send_word(CMD_END, 32'hFFFF_FFFF, 48'd8, 48'd8, 49'sd8);
      // invalid and negative CPU spans, exact and rounded-up spans
      send_word(CMD_BEGIN, 32'd7, 48'd10, 48'd10, -49'sd1);
      send_word(CMD_END, 32'd7, 48'd10, 48'd11, 49'sd1000);
      send_word(CMD_BEGIN, 32'd8, 48'd10, 48'd10, 49'sd5000);
      send_word(CMD_END, 32'd8, 48'd10, 48'd11, 49'sd4000);
      send_word(CMD_BEGIN, 32'd9, 48'd10, 48'd10, 49'sd1000);
      send_word(CMD_END, 32'd9, 48'd30, 48'd11, 49'sd1000);
      send_word(CMD_BEGIN, 32'd10, 48'd3, 48'd10, 49'sd1);
      send_word(CMD_END, 32'd10, 48'd4, 48'd11, 49'sd2);
      send_word(CMD_BEGIN, 32'd11, 48'd3, 48'd10, '0);
      send_word(CMD_END, 32'd11, 48'd4, 48'd11, 49'sd2000);

      // no idling, with one long receiver hold-off so the job queue backs up
      hold_on <= 1'b1;
      run_random(260);
      send_idle_pct = 79;
      recv_stall_pct = 0;
      run_random(260);
      send_idle_pct = 0;
      recv_stall_pct = 79;
      run_random(265);
      send_idle_pct = 27;
      recv_stall_pct = 27;
      run_random(265);
      req_valid <= 1'b0;

      while (board.pending_reports.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("run covered %0d words: directed corners and random windows",
               board.words_seen);
      $display("  %0d windows recorded, %0d ends discarded, under four idle patterns",
               board.recorded_seen, board.discarded_seen);
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d result words pending", board.pending_reports.size());
      $display("status: fail");
      $finish;
   end

endmodule
